### hw/rtl/frame_rate_meter_defines.svh
// ----------------------------------------------------------------------------
// Frame rate meter assertion macros
// Shared assertion wrappers. They expect signals named clock and reset in the
// module that uses them.
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_METER_DEFINES_SVH
`define FRAME_RATE_METER_DEFINES_SVH

// Checked on every edge outside of reset.
`define FRM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define FRM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate meter package
// Payload types, controller interface types and constants of the meter.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

   localparam int HISTORY_DEPTH_DEF = 16;

   localparam int NOW_W    = 32;
   localparam int FRAME_W  = 16;
   localparam int FPS_W    = 16;
   localparam int FEELS_W  = 24;
   localparam int WINDOW_W = 16;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
   localparam logic [FEELS_W-1:0]  FEELS_MAX    = 24'hFF_FFFF;

   // The weighted rate is ((1000 * sum + 10) << 8) / sum_of_squares.
   localparam int RATE_SCALE = 1000;
   localparam int RATE_BIAS  = 10;
   localparam int FRAC_BITS  = 8;

   typedef struct packed {
      logic [NOW_W-1:0]   now_ms;
      logic [FRAME_W-1:0] frame_ms;
   } req_type;

   typedef struct packed {
      logic [FPS_W-1:0]   fps;
      logic [FEELS_W-1:0] feels_like_fps;
      logic               window_closed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SUM,
      ST_DRAIN,
      ST_PREP,
      ST_DIV_INIT,
      ST_DIV,
      ST_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic eval;
      logic sum_issue;
      logic prep;
      logic div_init;
      logic div_step;
      logic write_hist;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic closed;
      logic idx_last;
      logic pipe_empty;
      logic div_last;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/frm_ram.sv
// ----------------------------------------------------------------------------
// Frame rate meter RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_ram #(
   parameter int WIDTH = frm_pkg::FRAME_W,
   parameter int DEPTH = frm_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/frm_ctrl.sv
// ----------------------------------------------------------------------------
// Frame rate meter controller
// Sequences one frame item: window check, history walk and division when a
// window closes, history update and hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire frm_pkg::status_type status,
   output      frm_pkg::cmd_type    cmd
);

   frm_pkg::state_type state_ff;
   frm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         frm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = frm_pkg::ST_EVAL;
            end
         end
         frm_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.closed) begin
               state_in = frm_pkg::ST_SUM;
            end else begin
               state_in = frm_pkg::ST_WRITE;
            end
         end
         frm_pkg::ST_SUM: begin
            cmd.sum_issue = 1'b1;
            if (status.idx_last) begin
               state_in = frm_pkg::ST_DRAIN;
            end
         end
         frm_pkg::ST_DRAIN: begin
            if (status.pipe_empty) begin
               state_in = frm_pkg::ST_PREP;
            end
         end
         frm_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = frm_pkg::ST_DIV_INIT;
         end
         frm_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = frm_pkg::ST_DIV;
         end
         frm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = frm_pkg::ST_WRITE;
            end
         end
         frm_pkg::ST_WRITE: begin
            cmd.write_hist = 1'b1;
            state_in       = frm_pkg::ST_OUT;
         end
         frm_pkg::ST_OUT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = frm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/frm_datapath.sv
// ----------------------------------------------------------------------------
// Frame rate meter datapath
// Window registers, duration history, sum and sum-of-squares accumulator,
// radix-2 divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_rate_meter_defines.svh"

module frm_datapath #(
   parameter int HISTORY_DEPTH = frm_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire frm_pkg::cmd_type                  cmd,
   output      frm_pkg::status_type               status,
   input  wire frm_pkg::req_type                  req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      frm_pkg::rsp_type                  rsp_data,
   input  wire logic                              csr_valid,
   input  wire logic [frm_pkg::WINDOW_W-1:0]      csr_data
);

   localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FW   = $clog2(HISTORY_DEPTH + 1);
   localparam int LW   = $clog2(HISTORY_DEPTH);
   localparam int DW   = frm_pkg::FRAME_W;
   localparam int PW   = 2 * frm_pkg::FRAME_W;
   localparam int S1W  = DW + LW;
   localparam int S2W  = PW + LW;
   localparam int SCW  = S1W + $clog2(frm_pkg::RATE_SCALE);
   localparam int QW   = frm_pkg::FEELS_W;
   localparam int NUMW = SCW + frm_pkg::FRAC_BITS;
   localparam int TOPW = NUMW - QW;
   localparam int CW   = $clog2(QW);

   // Configuration and window state.
   logic [frm_pkg::WINDOW_W-1:0] window_ms_ff, window_ms_in;
   logic [frm_pkg::NOW_W-1:0]    now_ff, now_in;
   logic [DW-1:0]                dur_ff, dur_in;
   logic [frm_pkg::FPS_W-1:0]    frame_counter_ff, frame_counter_in;
   logic [frm_pkg::NOW_W-1:0]    window_start_ff, window_start_in;
   logic [frm_pkg::FPS_W-1:0]    fps_latch_ff, fps_latch_in;
   logic [QW-1:0]                feels_latch_ff, feels_latch_in;
   logic                         closed_ff, closed_in;

   // History walk.
   logic [AW-1:0]  idx_ff, idx_in;
   logic           live_ff, live_in;
   logic           pv_ff, pv_in;
   logic [DW-1:0]  d_ff, d_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic [S1W-1:0] s1_ff, s1_in;
   logic [S2W-1:0] s2_ff, s2_in;
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FW-1:0]  fill_ff, fill_in;

   // Divider.
   logic [NUMW-1:0] num_ff, num_in;
   logic [S2W-1:0]  rem_ff, rem_in;
   logic [QW-1:0]   lo_ff, lo_in;
   logic            sat_ff, sat_in;
   logic [CW-1:0]   div_cnt_ff, div_cnt_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   frm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [DW-1:0]            rd_data;
   logic [DW-1:0]            d_masked;
   logic [frm_pkg::NOW_W-1:0] elapsed;
   logic                     closed_now;
   logic [frm_pkg::FPS_W-1:0] counter_inc;
   logic [SCW-1:0]           scaled;
   logic [TOPW-1:0]          num_top;
   logic [S2W:0]             rem_shift;
   logic [S2W:0]             rem_diff;
   logic                     div_ge;
   logic                     rsp_free;

   frm_ram #(
      .WIDTH (DW),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.write_hist),
      .wr_addr (wr_ptr_ff),
      .wr_data (dur_ff),
      .rd_en   (cmd.sum_issue),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign elapsed     = now_ff - window_start_ff;
   assign closed_now  = elapsed >= frm_pkg::NOW_W'(window_ms_ff);
   assign counter_inc = (frame_counter_ff == '1) ? frame_counter_ff
                                                 : frame_counter_ff + 1'b1;

   // Entries beyond the fill count have never been written and count as zero.
   assign d_masked = live_ff ? rd_data : '0;

   assign scaled  = SCW'(s1_ff) * SCW'(frm_pkg::RATE_SCALE) + SCW'(frm_pkg::RATE_BIAS);
   assign num_top = num_ff[NUMW-1:QW];

   assign rem_shift = {rem_ff, lo_ff[QW-1]};
   assign rem_diff  = rem_shift - {1'b0, s2_ff};
   assign div_ge    = rem_shift >= {1'b0, s2_ff};

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      window_ms_in     = window_ms_ff;
      now_in           = now_ff;
      dur_in           = dur_ff;
      frame_counter_in = frame_counter_ff;
      window_start_in  = window_start_ff;
      fps_latch_in     = fps_latch_ff;
      feels_latch_in   = feels_latch_ff;
      closed_in        = closed_ff;
      idx_in           = idx_ff;
      s1_in            = s1_ff;
      s2_in            = s2_ff;
      wr_ptr_in        = wr_ptr_ff;
      fill_in          = fill_ff;
      num_in           = num_ff;
      rem_in           = rem_ff;
      lo_in            = lo_ff;
      sat_in           = sat_ff;
      div_cnt_in       = div_cnt_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;

      live_in = cmd.sum_issue && (FW'(idx_ff) < fill_ff);
      pv_in   = live_ff;
      d_in    = d_masked;
      prod_in = PW'(d_masked) * PW'(d_masked);

      if (csr_valid) begin
         window_ms_in = csr_data;
      end

      if (cmd.load_in) begin
         now_in = req_data.now_ms;
         dur_in = req_data.frame_ms;
      end

      if (cmd.eval) begin
         closed_in = closed_now;
         if (closed_now) begin
            window_start_in  = now_ff;
            fps_latch_in     = counter_inc;
            frame_counter_in = '0;
            idx_in           = '0;
            s1_in            = '0;
            s2_in            = '0;
         end else begin
            frame_counter_in = counter_inc;
         end
      end

      if (cmd.sum_issue) begin
         idx_in = (idx_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
      end

      if (pv_ff) begin
         s1_in = s1_ff + S1W'(d_ff);
         s2_in = s2_ff + S2W'(prod_ff);
      end

      if (cmd.prep) begin
         num_in = {scaled, {frm_pkg::FRAC_BITS{1'b0}}};
      end

      // A quotient that does not fit in QW bits, or a zero divisor, saturates.
      if (cmd.div_init) begin
         sat_in     = S2W'(num_top) >= s2_ff;
         rem_in     = S2W'(num_top);
         lo_in      = num_ff[QW-1:0];
         div_cnt_in = '0;
      end

      if (cmd.div_step) begin
         rem_in     = div_ge ? rem_diff[S2W-1:0] : rem_shift[S2W-1:0];
         lo_in      = {lo_ff[QW-2:0], div_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (cmd.write_hist) begin
         wr_ptr_in = (wr_ptr_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (fill_ff != FW'(HISTORY_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
         if (closed_ff) begin
            feels_latch_in = sat_ff ? frm_pkg::FEELS_MAX : lo_ff;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.fps            = fps_latch_ff;
         rsp_data_in.feels_like_fps = feels_latch_ff;
         rsp_data_in.window_closed  = closed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff     <= frm_pkg::WINDOW_RESET;
         frame_counter_ff <= '0;
         window_start_ff  <= '0;
         fps_latch_ff     <= '0;
         feels_latch_ff   <= '0;
         closed_ff        <= 1'b0;
         idx_ff           <= '0;
         live_ff          <= 1'b0;
         pv_ff            <= 1'b0;
         s1_ff            <= '0;
         s2_ff            <= '0;
         wr_ptr_ff        <= '0;
         fill_ff          <= '0;
         sat_ff           <= 1'b0;
         div_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         window_ms_ff     <= window_ms_in;
         frame_counter_ff <= frame_counter_in;
         window_start_ff  <= window_start_in;
         fps_latch_ff     <= fps_latch_in;
         feels_latch_ff   <= feels_latch_in;
         closed_ff        <= closed_in;
         idx_ff           <= idx_in;
         live_ff          <= live_in;
         pv_ff            <= pv_in;
         s1_ff            <= s1_in;
         s2_ff            <= s2_in;
         wr_ptr_ff        <= wr_ptr_in;
         fill_ff          <= fill_in;
         sat_ff           <= sat_in;
         div_cnt_ff       <= div_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      dur_ff      <= dur_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      lo_ff       <= lo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.closed     = closed_now;
   assign status.idx_last   = idx_ff == AW'(HISTORY_DEPTH - 1);
   assign status.pipe_empty = !live_ff && !pv_ff;
   assign status.div_last   = div_cnt_ff == CW'(QW - 1);
   assign status.rsp_free   = rsp_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FRM_ASSERT(a_fill_bounded, (fill_ff <= FW'(HISTORY_DEPTH)), "fill count beyond depth")
   `FRM_ASSERT(a_counter_cleared, (cmd.eval && closed_now) |=> (frame_counter_ff == '0), "count not cleared on window close")
   `FRM_ASSERT(a_rem_below_divisor, (cmd.div_step && !sat_ff) |-> (rem_ff < s2_ff), "divider remainder out of range")
   `FRM_ASSERT(a_load_when_free, cmd.load_rsp |-> rsp_free, "result loaded over a pending item")

endmodule

`default_nettype wire

### hw/rtl/frame_rate_meter.sv
// ----------------------------------------------------------------------------
// Frame rate meter
// Counts frames per window and computes a weighted "feels like" frame rate
// over a history of recent frame durations.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Ports                           Moves
//   req       in          req_valid/req_ready/req_data    one frame item
//   rsp       out         rsp_valid/rsp_ready/rsp_data    one result item
//   csr       in          csr_valid/csr_ready/csr_data    window length write
//
// A frame that does not close a window passes the window check, the history
// update and the hand-off to the result register before the next acceptance.
// A frame that closes one also walks the whole history before the update:
// the history RAM is read one entry per cycle, then a radix-2 divider yields
// one quotient bit per cycle of its 24-bit quotient. The result register lets
// the next item be accepted while the last result still waits on rsp_ready.
// Reset is synchronous; the history reads as zero until entries are written.
//
`default_nettype none

module frame_rate_meter #(
   parameter int HISTORY_DEPTH = frm_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire frm_pkg::req_type              req_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      frm_pkg::rsp_type              rsp_data,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [frm_pkg::WINDOW_W-1:0]  csr_data
);

   frm_pkg::cmd_type    cmd;
   frm_pkg::status_type status;

   // The window register can be written on any cycle.
   assign csr_ready = 1'b1;

   frm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   frm_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire
